>>> src/brfd_pkg.sv
`default_nettype none

package brfd_pkg;

    // ring size and derived widths
    localparam int DEPTH = 4096;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // fixed field widths of the beats
    localparam int ACTION_W = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W = 13;
    localparam int OFFS_W = 12;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W = 13;

    // width used when comparing counts against run lengths
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    // width of head plus offset before the wrap correction
    localparam int SUM_W = ((ADDR_W > OFFS_W) ? ADDR_W : OFFS_W) + 1;

    // packed beat widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 40;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_WRITE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_UNTIL = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TOO_FEW   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_PEEK_OOR  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic                take_item;
        logic                set_refused;
        logic                refused_val;
        logic                push;
        logic                pop;
        logic                peek;
        logic                clear;
        logic                scan_start;
        logic                scan_step;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_cmp;
        logic                res_capture;
        logic                res_scan;
        logic                out_load;
    } brfd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                run_first;
        logic                refused;
        logic                wr_fits;
        logic                rd_fits;
        logic                fill_zero;
        logic                fill_full;
        logic                peek_ok;
        logic                scan_done;
        logic                out_free;
    } brfd_stat_t;

    // successor of a ring index with wrap at DEPTH
    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W:0] inc;
        inc = {1'b0, idx} + {{ADDR_W{1'b0}}, 1'b1};
        if (inc >= (ADDR_W+1)'(DEPTH)) begin
            return '0;
        end else begin
            return inc[ADDR_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> src/brfd_dp.sv
`default_nettype none

module brfd_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire brfd_pkg::brfd_cmd_t           cmd,
    output brfd_pkg::brfd_stat_t               stat,
    input  wire logic [brfd_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [brfd_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [brfd_pkg::M_TDATA_W-1:0]     m_tdata
);

    // byte store
    logic [brfd_pkg::BYTE_W-1:0] mem [brfd_pkg::DEPTH];
    logic [brfd_pkg::ADDR_W-1:0] rd_addr;
    logic [brfd_pkg::BYTE_W-1:0] rd_data_reg;

    // ring control
    logic [brfd_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [brfd_pkg::ADDR_W-1:0] tail_reg, tail_next;
    logic [brfd_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic                        refused_reg, refused_next;

    // latched item
    logic [brfd_pkg::ACTION_W-1:0] act_reg;
    logic                          first_reg;
    logic [brfd_pkg::BYTE_W-1:0]   wbyte_reg;
    logic [brfd_pkg::LEN_W-1:0]    rlen_reg;
    logic [brfd_pkg::OFFS_W-1:0]   offs_reg;
    logic [brfd_pkg::BYTE_W-1:0]   delim_reg;

    // search walk
    logic [brfd_pkg::ADDR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [brfd_pkg::CNT_W-1:0]  scan_left_reg, scan_left_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic                        scan_hit;

    // pending result
    logic [brfd_pkg::BYTE_W-1:0]   res_byte_reg, res_byte_next;
    logic                          res_found_reg, res_found_next;
    logic [brfd_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          res_cmp_reg, res_cmp_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic [brfd_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [brfd_pkg::CNT_W-1:0]  free_now;
    logic [brfd_pkg::SUM_W-1:0]  peek_sum;
    logic [brfd_pkg::ADDR_W-1:0] peek_addr;
    logic [brfd_pkg::LEVEL_W-1:0] lvl_fill, lvl_free;

    assign free_now = brfd_pkg::CNT_W'(brfd_pkg::DEPTH) - fill_reg;

    assign peek_sum = brfd_pkg::SUM_W'(head_reg) + brfd_pkg::SUM_W'(offs_reg);
    always_comb begin
        if (peek_sum >= brfd_pkg::SUM_W'(brfd_pkg::DEPTH)) begin
            peek_addr = brfd_pkg::ADDR_W'(peek_sum - brfd_pkg::SUM_W'(brfd_pkg::DEPTH));
        end else begin
            peek_addr = brfd_pkg::ADDR_W'(peek_sum);
        end
    end

    always_comb begin
        if (cmd.scan_step) begin
            rd_addr = scan_ptr_reg;
        end else if (cmd.peek) begin
            rd_addr = peek_addr;
        end else begin
            rd_addr = head_reg;
        end
    end

    assign scan_hit = cmp_valid_reg && (rd_data_reg == delim_reg);

    always_comb begin
        stat.action    = act_reg;
        stat.run_first = first_reg;
        stat.refused   = refused_reg;
        stat.wr_fits   = brfd_pkg::CMP_W'(rlen_reg) <= brfd_pkg::CMP_W'(free_now);
        stat.rd_fits   = brfd_pkg::CMP_W'(rlen_reg) <= brfd_pkg::CMP_W'(fill_reg);
        stat.fill_zero = fill_reg == '0;
        stat.fill_full = fill_reg >= brfd_pkg::CNT_W'(brfd_pkg::DEPTH);
        stat.peek_ok   = brfd_pkg::CMP_W'(offs_reg) < brfd_pkg::CMP_W'(fill_reg);
        stat.scan_done = scan_hit || (scan_left_reg == '0);
        stat.out_free  = !out_valid_reg || m_tready;
    end

    // ring state update
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        refused_next = refused_reg;
        if (cmd.set_refused) begin
            refused_next = cmd.refused_val;
        end
        if (cmd.push) begin
            tail_next = brfd_pkg::ring_next(tail_reg);
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.pop) begin
            head_next = brfd_pkg::ring_next(head_reg);
            fill_next = fill_reg - 1'b1;
        end
        if (cmd.clear) begin
            head_next    = '0;
            tail_next    = '0;
            fill_next    = '0;
            refused_next = 1'b0;
        end
    end

    // search walk, one read issued per cycle
    always_comb begin
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        cmp_valid_next = cmp_valid_reg;
        if (cmd.scan_start) begin
            scan_ptr_next  = head_reg;
            scan_left_next = fill_reg;
            cmp_valid_next = 1'b0;
        end else if (cmd.scan_step) begin
            if (scan_left_reg != '0) begin
                scan_ptr_next  = brfd_pkg::ring_next(scan_ptr_reg);
                scan_left_next = scan_left_reg - 1'b1;
                cmp_valid_next = 1'b1;
            end else begin
                cmp_valid_next = 1'b0;
            end
        end
    end

    // pending result
    always_comb begin
        res_byte_next   = res_byte_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_cmp_next    = res_cmp_reg;
        if (cmd.res_load) begin
            res_byte_next   = '0;
            res_found_next  = 1'b0;
            res_status_next = cmd.res_status;
            res_cmp_next    = cmd.res_cmp;
        end
        if (cmd.res_capture) begin
            res_byte_next  = rd_data_reg;
            res_found_next = res_cmp_reg && (rd_data_reg == delim_reg);
        end
        if (cmd.res_scan) begin
            res_found_next = scan_hit;
        end
    end

    assign lvl_fill = brfd_pkg::LEVEL_W'(fill_reg);
    assign lvl_free = brfd_pkg::LEVEL_W'(free_now);

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, lvl_free, lvl_fill, res_status_reg,
                              res_found_reg, res_byte_reg};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail_reg] <= wbyte_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            refused_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            refused_reg   <= refused_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            act_reg   <= s_tuser[2:0];
            first_reg <= s_tuser[3];
            wbyte_reg <= s_tdata[7:0];
            rlen_reg  <= s_tdata[20:8];
            offs_reg  <= s_tdata[32:21];
            delim_reg <= s_tdata[40:33];
        end
        scan_ptr_reg   <= scan_ptr_next;
        scan_left_reg  <= scan_left_next;
        cmp_valid_reg  <= cmp_valid_next;
        res_byte_reg   <= res_byte_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        res_cmp_reg    <= res_cmp_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> src/brfd_ctrl.sv
`default_nettype none

module brfd_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire brfd_pkg::brfd_stat_t stat,
    output brfd_pkg::brfd_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SEARCH,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   refused_eff;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        refused_eff = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.take_item = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.res_load   = 1'b1;
                cmd.res_status = brfd_pkg::STAT_OK;
                state_next     = ST_FIN;
                case (stat.action)
                    brfd_pkg::ACT_WRITE: begin
                        cmd.set_refused = stat.run_first;
                        cmd.refused_val = !stat.wr_fits;
                        refused_eff = stat.run_first ? !stat.wr_fits : stat.refused;
                        if (refused_eff || stat.fill_full) begin
                            cmd.res_status = brfd_pkg::STAT_NO_SPACE;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end
                    brfd_pkg::ACT_READ: begin
                        cmd.set_refused = stat.run_first;
                        cmd.refused_val = !stat.rd_fits;
                        refused_eff = stat.run_first ? !stat.rd_fits : stat.refused;
                        if (refused_eff || stat.fill_zero) begin
                            cmd.res_status = brfd_pkg::STAT_TOO_FEW;
                        end else begin
                            cmd.pop    = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                    end
                    brfd_pkg::ACT_PEEK: begin
                        if (stat.peek_ok) begin
                            cmd.peek   = 1'b1;
                            state_next = ST_RDWAIT;
                        end else begin
                            cmd.res_status = brfd_pkg::STAT_PEEK_OOR;
                        end
                    end
                    brfd_pkg::ACT_SEARCH: begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SEARCH;
                    end
                    brfd_pkg::ACT_READ_UNTIL: begin
                        if (stat.fill_zero) begin
                            cmd.res_status = brfd_pkg::STAT_TOO_FEW;
                        end else begin
                            cmd.pop     = 1'b1;
                            cmd.res_cmp = 1'b1;
                            state_next  = ST_RDWAIT;
                        end
                    end
                    brfd_pkg::ACT_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_RDWAIT: begin
                cmd.res_capture = 1'b1;
                state_next      = ST_FIN;
            end
            ST_SEARCH: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    cmd.res_scan = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

>>> src/byte_ring_fifo_with_delimiter_top.sv
// byte ring fifo of 4096 entries with delimiter search. each input beat carries one
// action (write, read, peek, search, read-until, clear) and gives exactly one result
// beat with the byte read, a found flag, a status code and the fill and free levels
// after the action. write and read runs are checked whole on the beat that has
// run_first set: a run longer than the free space (write) or fill (read) is refused
// and every beat of it reports the refusal. items are handled one at a time:
// write, clear, the unused action codes and refused, empty-ring or out-of-range
// actions pass through the idle, exec and fin states; read, peek and read-until
// add the rdwait state for the registered store read, and search walks the
// store one byte per cycle from the head and stops early on the first match. a
// result still waiting on m_tready holds back only the hand-over of the next one.
// the result register frees the input side, so a new beat is taken while the
// previous result still waits on m_tready. no clearing pass is needed after reset.
`default_nettype none

module byte_ring_fifo_with_delimiter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beat
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // write_byte[7:0], run_length[20:8], byte_offset[32:21], delimiter[40:33], zero pad
    input  wire logic [47:0] s_tdata,
    // action[2:0], run_first[3]
    input  wire logic [3:0]  s_tuser,
    // result beat
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_byte[7:0], found[8], status[10:9], fill_level[23:11], free_space[36:24], pad
    output logic [39:0]      m_tdata
);

    brfd_pkg::brfd_cmd_t  cmd;
    brfd_pkg::brfd_stat_t stat;

    // sequencer: takes a beat, steps the action, hands the result on
    brfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, ring pointers, search walk and result register
    brfd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> tb/tb_byte_ring_fifo_with_delimiter_top.sv
module tb_byte_ring_fifo_with_delimiter_top;

    timeunit 1ns;
    timeprecision 1ps;

    import brfd_pkg::*;

    // unused action codes, the block treats them as a no-op
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    // one request beat, unpacked into its fields
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   write_byte;
        logic                run_first;
        logic [LEN_W-1:0]    run_length;
        logic [OFFS_W-1:0]   byte_offset;
        logic [BYTE_W-1:0]   delimiter;
    } ring_req_t;

    // one reply beat
    typedef struct packed {
        logic [BYTE_W-1:0]   rd_byte;
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  fill_level;
        logic [LEVEL_W-1:0]  free_space;
    } ring_reply_t;

    // receiver back-pressure patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_QUARTER,
        RX_COIN
    } rx_mode_t;

    // dut ports, every input known from time zero
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // write_byte[7:0], run_length[20:8], byte_offset[32:21], delimiter[40:33], zero pad
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // action[2:0], run_first[3]
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // read_byte[7:0], found[8], status[10:9], fill_level[23:11], free_space[36:24], pad
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow copy of the ring, updated as each request beat is taken
    logic [BYTE_W-1:0]    ring_mem [DEPTH];
    logic [ADDR_W-1:0]    ring_head = '0;
    logic [ADDR_W-1:0]    ring_tail = '0;
    logic [CNT_W-1:0]     ring_fill = '0;
    logic                 run_blocked = 1'b0;

    // replies still owed by the block, oldest first
    ring_reply_t          expected_beats [$];
    int unsigned          mismatches = 0;
    int unsigned          replies_seen = 0;

    // sender pacing
    int unsigned          burst_left = 0;
    bit                   steady = 1'b0;

    // receiver pacing
    rx_mode_t             rx_mode = RX_OPEN;
    int unsigned          rx_span = 0;
    int unsigned          rx_tick = 0;

    byte_ring_fifo_with_delimiter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // ring behaviour
    // ---------------------------------------------------------------

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] idx);
        return (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // pop the byte at the head
    function automatic logic [BYTE_W-1:0] take_oldest();
        logic [BYTE_W-1:0] b;
        b = ring_mem[ring_head];
        ring_head = next_slot(ring_head);
        ring_fill = ring_fill - 1'b1;
        return b;
    endfunction

    // apply one request to the shadow ring and work out its reply
    function automatic ring_reply_t ring_predict(input ring_req_t r);
        ring_reply_t y;
        int unsigned room;
        int unsigned k;
        int unsigned pos;
        y = '0;
        room = DEPTH - ring_fill;
        case (r.action)
            ACT_WRITE: begin
                // the run is judged on its first beat, a refusal sticks
                if (r.run_first) begin
                    run_blocked = (r.run_length > room);
                end
                if (run_blocked || ring_fill >= DEPTH) begin
                    y.status = STAT_NO_SPACE;
                end else begin
                    ring_mem[ring_tail] = r.write_byte;
                    ring_tail = next_slot(ring_tail);
                    ring_fill = ring_fill + 1'b1;
                end
            end
            ACT_READ: begin
                if (r.run_first) begin
                    run_blocked = (r.run_length > ring_fill);
                end
                if (run_blocked || ring_fill == 0) begin
                    y.status = STAT_TOO_FEW;
                end else begin
                    y.rd_byte = take_oldest();
                end
            end
            ACT_PEEK: begin
                if (r.byte_offset < ring_fill) begin
                    y.rd_byte = ring_mem[(int'(ring_head) + int'(r.byte_offset)) % DEPTH];
                end else begin
                    y.status = STAT_PEEK_OOR;
                end
            end
            ACT_SEARCH: begin
                // walk every held byte from the head, full ring included
                pos = ring_head;
                for (k = 0; k < ring_fill && !y.found; k++) begin
                    if (ring_mem[pos] == r.delimiter) begin
                        y.found = 1'b1;
                    end
                    pos = (pos + 1) % DEPTH;
                end
            end
            ACT_READ_UNTIL: begin
                // the delimiter is consumed like any other byte
                if (ring_fill == 0) begin
                    y.status = STAT_TOO_FEW;
                end else begin
                    y.rd_byte = take_oldest();
                    y.found = (y.rd_byte == r.delimiter);
                end
            end
            ACT_CLEAR: begin
                ring_head = '0;
                ring_tail = '0;
                ring_fill = '0;
                run_blocked = 1'b0;
            end
            default: begin
            end
        endcase
        y.fill_level = LEVEL_W'(ring_fill);
        y.free_space = LEVEL_W'(DEPTH - ring_fill);
        return y;
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // all fields random, so unused fields toggle too
    function automatic ring_req_t base_beat(input logic [ACTION_W-1:0] act);
        ring_req_t r;
        r.action = act;
        r.write_byte = BYTE_W'($urandom);
        r.run_first = 1'($urandom);
        r.run_length = LEN_W'($urandom);
        r.byte_offset = OFFS_W'($urandom);
        r.delimiter = BYTE_W'($urandom);
        return r;
    endfunction

    // present one beat, wait for the handshake, then maybe leave a gap
    task automatic send_beat(input ring_req_t r);
        int unsigned gap;
        s_tdata <= {7'd0, r.delimiter, r.byte_offset, r.run_length, r.write_byte};
        s_tuser <= {r.run_first, r.action};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        expected_beats.push_back(ring_predict(r));
        if (!steady && burst_left == 0) begin
            // gap before the next beat so valid never drops and rises in one step
            s_tvalid <= 1'b0;
            gap = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end else if (burst_left != 0) begin
            burst_left--;
        end
    endtask

    // beat for an action that takes no run
    task automatic send_op(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] delim,
                           input logic [OFFS_W-1:0] offs);
        ring_req_t r;
        r = base_beat(act);
        r.delimiter = delim;
        r.byte_offset = offs;
        send_beat(r);
    endtask

    // write run: first beat carries the length, bytes drawn from 0..top
    task automatic send_write_run(input int unsigned len, input int unsigned beats,
                                  input int unsigned top);
        ring_req_t r;
        int unsigned k;
        for (k = 0; k < beats; k++) begin
            r = base_beat(ACT_WRITE);
            r.run_first = (k == 0);
            if (k == 0) begin
                r.run_length = LEN_W'(len);
            end
            r.write_byte = BYTE_W'($urandom_range(0, top));
            send_beat(r);
        end
    endtask

    task automatic send_read_run(input int unsigned len, input int unsigned beats);
        ring_req_t r;
        int unsigned k;
        for (k = 0; k < beats; k++) begin
            r = base_beat(ACT_READ);
            r.run_first = (k == 0);
            if (k == 0) begin
                r.run_length = LEN_W'(len);
            end
            send_beat(r);
        end
    endtask

    // single write or read beat with chosen run flag and length
    task automatic send_run_beat(input logic [ACTION_W-1:0] act, input logic first,
                                 input int unsigned len, input logic [BYTE_W-1:0] b);
        ring_req_t r;
        r = base_beat(act);
        r.run_first = first;
        r.run_length = LEN_W'(len);
        r.write_byte = b;
        send_beat(r);
    endtask

    // stop sending until the block has answered everything
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) begin
            @(posedge aclk);
        end
        @(posedge aclk);
    endtask

    // mostly short runs, sometimes too long, zero, or anything the field holds
    function automatic int unsigned pick_run_length(input int unsigned room);
        int unsigned roll;
        int unsigned extra;
        roll = $urandom_range(0, 99);
        extra = $urandom_range(1, 6);
        if (roll < 78) begin
            return $urandom_range(1, 12);
        end else if (roll < 90) begin
            return (room + extra > 8191) ? 8191 : room + extra;
        end else if (roll < 95) begin
            return 0;
        end
        return $urandom_range(0, 8191);
    endfunction

    // beats to send for a run judged against room
    function automatic int unsigned pick_run_beats(input int unsigned len,
                                                   input int unsigned room);
        int unsigned beats;
        if (len > room) begin
            // refused run, a few trailing beats still report the refusal
            return 1 + $urandom_range(0, 3);
        end
        beats = (len == 0) ? 1 : ((len > 16) ? 16 : len);
        // now and then a run that stops short
        if ($urandom_range(0, 9) == 0) begin
            beats = $urandom_range(1, beats);
        end
        return beats;
    endfunction

    // ---------------------------------------------------------------
    // reply side
    // ---------------------------------------------------------------

    // receiver stalls follow a mode that is redrawn whenever its random span runs out
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_span == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_span <= $urandom_range(16, 400);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_SPARSE:  m_tready <= ($urandom_range(0, 7) == 0);
            RX_QUARTER: m_tready <= (rx_tick % 4 == 0);
            default:    m_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    function automatic void report_field(input string field, input int unsigned want,
                                         input int unsigned got);
        if (mismatches < 10) begin
            $display("reply %0d: %s expected %0d, got %0d", replies_seen, field, want, got);
        end
        mismatches++;
    endfunction

    // compare every reply beat with the oldest outstanding prediction
    always @(posedge aclk) begin
        ring_reply_t got;
        ring_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rd_byte = m_tdata[7:0];
            got.found = m_tdata[8];
            got.status = m_tdata[10:9];
            got.fill_level = m_tdata[23:11];
            got.free_space = m_tdata[36:24];
            if (expected_beats.size() == 0) begin
                if (mismatches < 10) begin
                    $display("reply %0d: beat %h with nothing outstanding", replies_seen,
                             m_tdata);
                end
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                if (got.rd_byte !== want.rd_byte) begin
                    report_field("read_byte", want.rd_byte, got.rd_byte);
                end
                if (got.found !== want.found) begin
                    report_field("found", want.found, got.found);
                end
                if (got.status !== want.status) begin
                    report_field("status", want.status, got.status);
                end
                if (got.fill_level !== want.fill_level) begin
                    report_field("fill_level", want.fill_level, got.fill_level);
                end
                if (got.free_space !== want.free_space) begin
                    report_field("free_space", want.free_space, got.free_space);
                end
            end
            replies_seen++;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // every action that needs bytes, plus the unused codes, on a ring that has none
    task automatic test_empty_ring();
        send_run_beat(ACT_READ, 1'b1, 1, 8'h00);
        send_op(ACT_READ_UNTIL, 8'h00, '0);
        send_op(ACT_PEEK, 8'h00, '0);
        send_op(ACT_PEEK, 8'hFF, '1);
        send_op(ACT_SEARCH, 8'hFF, '0);
        send_op(ACT_SPARE_LO, 8'h00, '0);
        send_op(ACT_SPARE_HI, 8'hFF, '1);
    endtask

    // runs judged whole on their first beat, refusal shared by writes and reads
    task automatic test_run_admission();
        send_run_beat(ACT_WRITE, 1'b1, DEPTH + 1, 8'h11);
        send_run_beat(ACT_WRITE, 1'b0, 0, 8'h22);
        // zero length always fits
        send_run_beat(ACT_WRITE, 1'b1, 0, 8'hA5);
        send_run_beat(ACT_WRITE, 1'b1, 3, 8'h00);
        send_run_beat(ACT_WRITE, 1'b0, 0, 8'hFF);
        send_run_beat(ACT_WRITE, 1'b0, 0, 8'h5A);
        // read longer than fill is refused, and a later write sees the refusal
        send_run_beat(ACT_READ, 1'b1, 5, 8'h00);
        send_run_beat(ACT_WRITE, 1'b0, 0, 8'h77);
        send_run_beat(ACT_READ, 1'b1, 2, 8'h00);
        send_run_beat(ACT_READ, 1'b0, 0, 8'h00);
        // clear drops the refusal as well as the bytes
        send_op(ACT_CLEAR, 8'h00, '0);
        send_run_beat(ACT_WRITE, 1'b0, 0, 8'h3C);
    endtask

    task automatic test_peek_and_search();
        send_run_beat(ACT_WRITE, 1'b1, 2, 8'hFF);
        send_run_beat(ACT_WRITE, 1'b0, 0, 8'h81);
        send_op(ACT_PEEK, 8'h00, 12'd0);
        send_op(ACT_PEEK, 8'h00, 12'd2);
        send_op(ACT_PEEK, 8'h00, 12'd3);
        // match only on the last held byte, then no match at all
        send_op(ACT_SEARCH, 8'h81, '0);
        send_op(ACT_SEARCH, 8'h7E, '0);
        send_op(ACT_READ_UNTIL, 8'h3C, '0);
        send_op(ACT_READ_UNTIL, 8'h00, '0);
    endtask

    // fill to the brim, move the head and tail past the end, drain across the wrap
    task automatic test_full_ring_wrap();
        int unsigned k;
        logic [BYTE_W-1:0] delim;
        send_op(ACT_CLEAR, 8'h00, '0);
        // the fill goes out back to back, no idling
        steady = 1'b1;
        send_write_run(DEPTH, DEPTH - 1, 8'hFD);
        steady = 1'b0;
        send_run_beat(ACT_WRITE, 1'b0, 0, 8'hFE);
        // admitted but the ring is full, byte dropped
        send_run_beat(ACT_WRITE, 1'b1, 0, 8'h99);
        send_op(ACT_SEARCH, 8'hFF, '0);
        send_op(ACT_PEEK, 8'h00, OFFS_W'(DEPTH - 1));
        send_read_run(100, 100);
        send_write_run(100, 99, 8'hFD);
        send_run_beat(ACT_WRITE, 1'b0, 0, 8'hFF);
        // full again with the tail wrapped, match on the very last byte
        send_op(ACT_SEARCH, 8'hFF, '0);
        send_op(ACT_SEARCH, 8'hFE, '0);
        send_op(ACT_PEEK, 8'h00, OFFS_W'(DEPTH - 1));
        send_run_beat(ACT_WRITE, 1'b1, 1, 8'h42);
        send_run_beat(ACT_READ, 1'b1, DEPTH + 1, 8'h00);
        // drain one byte at a time, the head wraps on the way
        for (k = 0; k < DEPTH; k++) begin
            delim = ($urandom_range(0, 1) == 1) ? ring_mem[ring_head] : BYTE_W'($urandom);
            send_op(ACT_READ_UNTIL, delim, OFFS_W'($urandom));
        end
        send_op(ACT_READ_UNTIL, 8'h00, '0);
    endtask

    // mostly well-formed runs with random content, plus peeks, searches and noise
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned write_share;
        int unsigned len;
        int unsigned beats;
        logic [BYTE_W-1:0] delim;
        logic [OFFS_W-1:0] offs;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) == 0) begin
                steady = !steady;
            end
            // keep the fill modest so searches stay short
            write_share = (ring_fill < 256) ? 30 : 8;
            pick = $urandom_range(0, 99);
            if (pick < write_share) begin
                len = pick_run_length(DEPTH - ring_fill);
                beats = pick_run_beats(len, DEPTH - ring_fill);
                send_write_run(len, beats, 255);
                sent += beats;
            end else if (pick < 50) begin
                len = pick_run_length(ring_fill);
                beats = pick_run_beats(len, ring_fill);
                send_read_run(len, beats);
                sent += beats;
            end else if (pick < 62) begin
                offs = (ring_fill != 0 && $urandom_range(0, 9) < 7)
                     ? OFFS_W'($urandom_range(0, ring_fill - 1)) : OFFS_W'($urandom);
                send_op(ACT_PEEK, BYTE_W'($urandom), offs);
                sent++;
            end else if (pick < 74) begin
                delim = BYTE_W'($urandom);
                if (ring_fill != 0 && $urandom_range(0, 1) == 1) begin
                    delim = ring_mem[(int'(ring_head) + $urandom_range(0, ring_fill - 1))
                                     % DEPTH];
                end
                send_op(ACT_SEARCH, delim, OFFS_W'($urandom));
                sent++;
            end else if (pick < 88) begin
                delim = (ring_fill != 0 && $urandom_range(0, 1) == 1)
                      ? ring_mem[ring_head] : BYTE_W'($urandom);
                send_op(ACT_READ_UNTIL, delim, OFFS_W'($urandom));
                sent++;
            end else if (pick < 91) begin
                send_op(ACT_CLEAR, BYTE_W'($urandom), OFFS_W'($urandom));
                sent++;
            end else if (pick < 93) begin
                send_op(($urandom_range(0, 1) == 1) ? ACT_SPARE_HI : ACT_SPARE_LO,
                        BYTE_W'($urandom), OFFS_W'($urandom));
                sent++;
            end else begin
                // stray beat, any action, run flag and length
                send_beat(base_beat(ACTION_W'($urandom)));
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        burst_left = $urandom_range(0, 15);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_ring();
        test_run_admission();
        test_peek_and_search();
        test_full_ring_wrap();
        test_random_traffic(525);
        // sender holds off until the block has answered everything
        wait_for_drain();
        test_random_traffic(525);

        wait_for_drain();
        // time for any stray reply beat to show up
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #24000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
